// ===== src/kss_pkg.sv =====
// Package for the keyed sprite slot table: payload structs, codes, defaults.
// Used by every module in src.
package kss_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam logic [15:0] THRESH_RESET = 16'd60;
    localparam logic [15:0] OFFSET_RESET = 16'd0;
    localparam logic [16:0] ACC_MAX = 17'h1ffff;

    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;
    localparam logic [1:0] REQ_VIEW   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_LISTEND  = 2'd3;

    localparam logic CFG_THRESH = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] reg_key;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] image_id;
        logic [7:0]  frame_total;
        logic [7:0]  frame_rate;
        logic [15:0] view_left;
        logic [15:0] view_top;
        logic [15:0] view_right;
        logic [15:0] view_bottom;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] tagged_index;
        logic [15:0] entry_y;
        logic [15:0] shown_image;
        logic [7:0]  shown_frame;
        logic [5:0]  tally;
        logic        last;
    } t_rsp;

endpackage

// ===== src/keyed_sprite_slot_table.sv =====
// Keyed sprite slot table: request queue feeding a slot-walking engine.
// The engine walks one slot per cycle and accepts a new request only after
// the last one is finished; the final item waits for a free output register.
// A view query also waits on result acceptance for each listed entry.
// Synchronous active-low reset clears slot valid bits and count, sets config defaults.
module keyed_sprite_slot_table #(
    parameter int SLOTS = kss_pkg::SLOTS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kss_pkg::t_req  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output kss_pkg::t_rsp  o_data,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [15:0]    i_cfg_data
);
    logic          q_valid;
    logic          q_ready;
    kss_pkg::t_req q_data;
    logic [15:0]   r_thresh;
    logic [15:0]   r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= kss_pkg::THRESH_RESET;
            r_offset <= kss_pkg::OFFSET_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == kss_pkg::CFG_THRESH) r_thresh <= i_cfg_data;
            else r_offset <= i_cfg_data;
        end
    end

    kss_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data(i_data),
        .o_valid(q_valid), .i_ready(q_ready), .o_data(q_data)
    );

    kss_engine #(.SLOTS(SLOTS)) u_engine (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_data),
        .i_thresh(r_thresh), .i_offset(r_offset),
        .o_valid(o_valid), .i_ready(i_ready), .o_rsp(o_data)
    );
endmodule

// ===== src/kss_queue.sv =====
// Two-entry request queue between the front and the back engine.
// Depends on kss_pkg.
module kss_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kss_pkg::t_req  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output kss_pkg::t_req  o_data
);
    kss_pkg::t_req r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    logic push;
    logic pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== src/kss_engine.sv =====
// Back engine: walks the slot table one slot per cycle for each request (view
// stalls on full output), emitting via an output register. Depends on kss_pkg.
module kss_engine #(
    parameter int SLOTS = kss_pkg::SLOTS_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kss_pkg::t_req  i_req,
    input  logic [15:0]    i_thresh,
    input  logic [15:0]    i_offset,
    output logic           o_valid,
    input  logic           i_ready,
    output kss_pkg::t_rsp  o_rsp
);
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_EMIT, S_WAIT} t_state;

    t_state        r_state;
    kss_pkg::t_req r_req;
    logic [CW-1:0] r_idx;
    logic          r_hit;
    logic          r_free;
    logic [SW-1:0] r_hit_slot;
    logic [SW-1:0] r_free_slot;
    logic [5:0]    r_count;
    logic [5:0]    r_listed;
    logic          r_ovalid;
    kss_pkg::t_rsp r_rsp;
    logic [SLOTS-1:0] r_valid;

    logic [15:0] r_key   [SLOTS];
    logic [15:0] r_x     [SLOTS];
    logic [15:0] r_y     [SLOTS];
    logic [15:0] r_image [SLOTS];
    logic [7:0]  r_frame [SLOTS];
    logic [7:0]  r_limit [SLOTS];
    logic [7:0]  r_rate  [SLOTS];
    logic [16:0] r_acc   [SLOTS];

    logic [SW-1:0] idx;
    logic          done;
    logic          out_free;
    logic [16:0]   acc_sub;
    logic [17:0]   acc_sum;
    logic [16:0]   acc_next;
    logic [8:0]    frame_inc;
    logic [7:0]    frame_next;
    logic          stepped;
    logic          inview;
    logic [SW-1:0] sel;
    logic          emit;
    kss_pkg::t_rsp apply_rsp;

    assign idx      = r_idx[SW-1:0];
    assign done     = (r_idx == CW'(SLOTS - 1));
    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_ovalid;
    assign o_rsp    = r_rsp;
    assign sel      = r_hit ? r_hit_slot : r_free_slot;
    assign emit     = out_free && ((r_state == S_APPLY)
                   || (r_state == S_SCAN && r_req.req_type == kss_pkg::REQ_VIEW
                       && r_valid[idx] && inview));

    always_comb begin
        stepped    = (r_acc[idx] >= {1'b0, i_thresh});
        acc_sub    = stepped ? (r_acc[idx] - {1'b0, i_thresh}) : r_acc[idx];
        frame_inc  = {1'b0, r_frame[idx]} + 9'd1;
        frame_next = (frame_inc >= {1'b0, r_limit[idx]}) ? 8'd0 : frame_inc[7:0];
        if (!stepped) frame_next = r_frame[idx];
        acc_sum    = {1'b0, acc_sub} + {10'd0, r_rate[idx]};
        acc_next   = acc_sum[17] ? kss_pkg::ACC_MAX : acc_sum[16:0];
        inview     = (r_x[idx] >= r_req.view_left) && (r_x[idx] <= r_req.view_right)
                  && (r_y[idx] >= r_req.view_top) && (r_y[idx] <= r_req.view_bottom);
    end

    // final item of the request
    always_comb begin
        apply_rsp = '{status: kss_pkg::ST_OK, tagged_index: 16'd0,
            entry_y: 16'd0, shown_image: 16'd0, shown_frame: 8'd0,
            tally: r_count, last: 1'b1};
        unique case (r_req.req_type)
            kss_pkg::REQ_ADD: begin
                if (r_hit || r_free) begin
                    apply_rsp.tagged_index = i_offset + 16'(sel);
                    if (!r_hit) apply_rsp.tally = r_count + 6'd1;
                end else begin
                    apply_rsp.status = kss_pkg::ST_FULL;
                end
            end
            kss_pkg::REQ_REMOVE: begin
                if (r_hit) begin
                    apply_rsp.tally        = r_count - 6'd1;
                    apply_rsp.tagged_index = i_offset + 16'(r_hit_slot);
                end else begin
                    apply_rsp.status = kss_pkg::ST_NOTFOUND;
                end
            end
            kss_pkg::REQ_TICK: begin
            end
            default: begin
                apply_rsp.status = kss_pkg::ST_LISTEND;
                apply_rsp.tally  = r_listed;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_count  <= 6'd0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
        end else begin
            if (emit) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req    <= i_req;
                        r_idx    <= '0;
                        r_hit    <= 1'b0;
                        r_free   <= 1'b0;
                        r_listed <= 6'd0;
                        r_state  <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    unique case (r_req.req_type)
                        kss_pkg::REQ_ADD, kss_pkg::REQ_REMOVE: begin
                            if (r_valid[idx] && r_key[idx] == r_req.reg_key && !r_hit) begin
                                r_hit      <= 1'b1;
                                r_hit_slot <= idx;
                            end
                            if (!r_valid[idx] && !r_free) begin
                                r_free      <= 1'b1;
                                r_free_slot <= idx;
                            end
                            r_idx <= r_idx + CW'(1);
                            if (done) r_state <= S_APPLY;
                        end
                        kss_pkg::REQ_TICK: begin
                            if (r_valid[idx]) begin
                                r_acc[idx]   <= acc_next;
                                r_frame[idx] <= frame_next;
                            end
                            r_idx <= r_idx + CW'(1);
                            if (done) r_state <= S_APPLY;
                        end
                        default: begin
                            // view: one slot per cycle, stall while output is full
                            if (out_free) begin
                                if (r_valid[idx] && inview) begin
                                    r_rsp <= '{status: kss_pkg::ST_OK,
                                        tagged_index: i_offset + 16'(idx),
                                        entry_y: r_y[idx], shown_image: r_image[idx],
                                        shown_frame: r_frame[idx], tally: r_count,
                                        last: 1'b0};
                                    r_listed <= r_listed + 6'd1;
                                end
                                r_idx <= r_idx + CW'(1);
                                if (done) r_state <= S_APPLY;
                            end
                        end
                    endcase
                end
                S_APPLY: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                        r_rsp   <= apply_rsp;
                        unique case (r_req.req_type)
                            kss_pkg::REQ_ADD: begin
                                if (r_hit || r_free) begin
                                    r_valid[sel] <= 1'b1;
                                    r_key[sel]   <= r_req.reg_key;
                                    r_x[sel]     <= r_req.pos_x;
                                    r_y[sel]     <= r_req.pos_y;
                                    r_image[sel] <= r_req.image_id;
                                    r_limit[sel] <= r_req.frame_total;
                                    r_rate[sel]  <= r_req.frame_rate;
                                    r_frame[sel] <= 8'd0;
                                    r_acc[sel]   <= 17'd0;
                                    if (!r_hit) r_count <= r_count + 6'd1;
                                end
                            end
                            kss_pkg::REQ_REMOVE: begin
                                if (r_hit) begin
                                    r_valid[r_hit_slot] <= 1'b0;
                                    r_count <= r_count - 6'd1;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sim/keyed_sprite_slot_table_tb.sv =====
// Testbench for keyed_sprite_slot_table: directed and random requests, with a
// built-in slot table predictor and in-order result checking.
// Depends on src/kss_pkg.sv and src/keyed_sprite_slot_table.sv.
`timescale 1ns / 1ps

module keyed_sprite_slot_table_tb;
    import kss_pkg::*;

    localparam int NSLOT = 32;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_req        i_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_rsp        o_data;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_THRESH;
    logic [15:0] i_cfg_data = '0;

    keyed_sprite_slot_table dut (.*);

    always #5 i_clk = ~i_clk;

    // table shadow
    logic        tb_valid [NSLOT];
    logic [15:0] tb_key   [NSLOT];
    logic [15:0] tb_x     [NSLOT];
    logic [15:0] tb_y     [NSLOT];
    logic [15:0] tb_img   [NSLOT];
    logic [7:0]  tb_frame [NSLOT];
    logic [7:0]  tb_limit [NSLOT];
    logic [7:0]  tb_rate  [NSLOT];
    logic [16:0] tb_acc   [NSLOT];
    logic [5:0]  tb_count;
    logic [15:0] tb_thresh;
    logic [15:0] tb_offset;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors = 0;
    int   hold_off = 0;
    bit   calm = 1'b0;
    bit   stim_done = 1'b0;

    function automatic t_rsp mk_rsp(logic [1:0] st, logic [15:0] idx, logic [15:0] y,
                                    logic [15:0] img, logic [7:0] frm, logic [5:0] tl,
                                    logic lst);
        t_rsp r;
        r.status = st; r.tagged_index = idx; r.entry_y = y; r.shown_image = img;
        r.shown_frame = frm; r.tally = tl; r.last = lst;
        return r;
    endfunction

    task automatic apply_request(input t_req q);
        int hit;
        int s;
        int n;
        logic [17:0] acc;
        logic [8:0]  f;
        hit = -1;
        s = -1;
        n = 0;
        case (q.req_type)
            REQ_ADD, REQ_REMOVE: begin
                for (int i = 0; i < NSLOT; i++)
                    if (hit < 0 && tb_valid[i] && tb_key[i] == q.reg_key) hit = i;
                if (q.req_type == REQ_REMOVE) begin
                    if (hit < 0) begin
                        expected_rsps.push_back(mk_rsp(ST_NOTFOUND, 0, 0, 0, 0, tb_count, 1));
                    end else begin
                        tb_valid[hit] = 1'b0;
                        tb_count = tb_count - 6'd1;
                        expected_rsps.push_back(mk_rsp(ST_OK, tb_offset + 16'(hit), 0, 0, 0,
                                                       tb_count, 1));
                    end
                end else begin
                    s = hit;
                    if (s < 0)
                        for (int i = 0; i < NSLOT; i++)
                            if (s < 0 && !tb_valid[i]) s = i;
                    if (s < 0) begin
                        expected_rsps.push_back(mk_rsp(ST_FULL, 0, 0, 0, 0, tb_count, 1));
                    end else begin
                        tb_valid[s] = 1'b1; tb_key[s] = q.reg_key;
                        tb_x[s] = q.pos_x; tb_y[s] = q.pos_y; tb_img[s] = q.image_id;
                        tb_limit[s] = q.frame_total; tb_rate[s] = q.frame_rate;
                        tb_frame[s] = '0; tb_acc[s] = '0;
                        if (hit < 0) tb_count = tb_count + 6'd1;
                        expected_rsps.push_back(mk_rsp(ST_OK, tb_offset + 16'(s), 0, 0, 0,
                                                       tb_count, 1));
                    end
                end
            end
            REQ_TICK: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tb_valid[i]) continue;
                    acc = {1'b0, tb_acc[i]};
                    if (acc >= {2'b00, tb_thresh}) begin
                        acc = acc - {2'b00, tb_thresh};
                        f = {1'b0, tb_frame[i]} + 9'd1;
                        tb_frame[i] = (f >= {1'b0, tb_limit[i]}) ? 8'd0 : f[7:0];
                    end
                    acc = acc + {10'd0, tb_rate[i]};
                    tb_acc[i] = (acc > {1'b0, ACC_MAX}) ? ACC_MAX : acc[16:0];
                end
                expected_rsps.push_back(mk_rsp(ST_OK, 0, 0, 0, 0, tb_count, 1));
            end
            default: begin
                for (int i = 0; i < NSLOT; i++) begin
                    if (!tb_valid[i]) continue;
                    if (tb_x[i] < q.view_left || tb_x[i] > q.view_right ||
                        tb_y[i] < q.view_top || tb_y[i] > q.view_bottom) continue;
                    expected_rsps.push_back(mk_rsp(ST_OK, tb_offset + 16'(i), tb_y[i],
                                                   tb_img[i], tb_frame[i], tb_count, 0));
                    n++;
                end
                expected_rsps.push_back(mk_rsp(ST_LISTEND, 0, 0, 0, 0, 6'(n), 1));
            end
        endcase
    endtask

    // Driver: present queued items, idling at random unless in a calm stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) apply_request(i_data);
            if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 28)) begin
                i_data  <= pending_reqs.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check accepted results and drive the receiver's stalls.
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rsps.size() == 0) begin
                $error("unexpected result %p", o_data);
                errors++;
            end else begin
                e = expected_rsps.pop_front();
                if (o_data.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_data.status); errors++;
                end
                if (o_data.tagged_index !== e.tagged_index) begin
                    $error("tagged_index exp %0d got %0d", e.tagged_index,
                           o_data.tagged_index); errors++;
                end
                if (o_data.entry_y !== e.entry_y) begin
                    $error("entry_y exp %0d got %0d", e.entry_y, o_data.entry_y); errors++;
                end
                if (o_data.shown_image !== e.shown_image) begin
                    $error("shown_image exp %0d got %0d", e.shown_image,
                           o_data.shown_image); errors++;
                end
                if (o_data.shown_frame !== e.shown_frame) begin
                    $error("shown_frame exp %0d got %0d", e.shown_frame,
                           o_data.shown_frame); errors++;
                end
                if (o_data.tally !== e.tally) begin
                    $error("tally exp %0d got %0d", e.tally, o_data.tally); errors++;
                end
                if (o_data.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_data.last); errors++;
                end
            end
        end
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_ready  <= 1'b0;
        end else begin
            i_ready <= calm || $urandom_range(99) >= 28;
        end
    end

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_THRESH) tb_thresh = val; else tb_offset = val;
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || i_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (NSLOT + 8) @(posedge i_clk);
    endtask

    function automatic t_req mk_req(logic [1:0] rt, logic [15:0] key);
        t_req q;
        q = '0;
        q.req_type = rt; q.reg_key = key;
        q.pos_x = $urandom; q.pos_y = $urandom; q.image_id = $urandom;
        q.frame_total = $urandom_range(0, 6); q.frame_rate = $urandom;
        q.view_left = 0; q.view_top = 0; q.view_right = 16'hffff; q.view_bottom = 16'hffff;
        return q;
    endfunction

    function automatic t_req rand_req(int keyspan);
        t_req q;
        int r;
        r = $urandom_range(99);
        q = mk_req(r < 40 ? REQ_ADD : r < 60 ? REQ_REMOVE : r < 80 ? REQ_TICK : REQ_VIEW,
                   $urandom_range(0, keyspan));
        if ($urandom_range(9) == 0) q.reg_key = $urandom_range(0, 65534);
        if ($urandom_range(3) == 0) q.frame_total = $urandom;
        if ($urandom_range(1)) begin
            q.view_left = $urandom; q.view_right = $urandom;
            q.view_top = $urandom;  q.view_bottom = $urandom;
            if ($urandom_range(1)) begin
                if (q.view_left > q.view_right) q.view_right = 16'hffff;
                if (q.view_top > q.view_bottom) q.view_bottom = 16'hffff;
            end
        end
        return q;
    endfunction

    initial begin
        t_req q;
        for (int i = 0; i < NSLOT; i++) tb_valid[i] = 1'b0;
        tb_count = '0; tb_thresh = THRESH_RESET; tb_offset = OFFSET_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, refresh, full table, missing key, empty view.
        q = mk_req(REQ_ADD, 16'd0); q.pos_x = 0; q.pos_y = 0; q.image_id = 0;
        q.frame_total = 0; q.frame_rate = 0; pending_reqs.push_back(q);
        q = mk_req(REQ_ADD, 16'hfffe); q.pos_x = 16'hffff; q.pos_y = 16'hffff;
        q.image_id = 16'hffff; q.frame_total = 8'hff; q.frame_rate = 8'hff;
        pending_reqs.push_back(q);
        q = mk_req(REQ_ADD, 16'd0); q.frame_total = 3; q.frame_rate = 8'd200;
        pending_reqs.push_back(q);
        pending_reqs.push_back(mk_req(REQ_REMOVE, 16'h1234));
        for (int i = 0; i < 4; i++) pending_reqs.push_back(mk_req(REQ_TICK, 0));
        pending_reqs.push_back(mk_req(REQ_VIEW, 0));
        q = mk_req(REQ_VIEW, 0); q.view_left = 16'hffff; q.view_right = 0;
        pending_reqs.push_back(q);
        q = mk_req(REQ_VIEW, 0); q.view_top = 16'hffff; q.view_bottom = 0;
        pending_reqs.push_back(q);
        q = mk_req(REQ_VIEW, 0); q.view_left = 16'hffff; q.view_top = 16'hffff;
        pending_reqs.push_back(q);
        for (int i = 1; i <= 31; i++) pending_reqs.push_back(mk_req(REQ_ADD, 100 + i));
        pending_reqs.push_back(mk_req(REQ_ADD, 16'd999));
        pending_reqs.push_back(mk_req(REQ_VIEW, 0));
        // long receiver hold-off while the sender keeps offering
        hold_off = 400;
        drain();

        // threshold 0: step every tick; offset near the top to wrap the index
        write_reg(CFG_THRESH, 16'd0);
        write_reg(CFG_OFFSET, 16'hffe8);
        for (int i = 0; i < 6; i++) pending_reqs.push_back(mk_req(REQ_TICK, 0));
        pending_reqs.push_back(mk_req(REQ_VIEW, 0));
        for (int i = 0; i < 24; i++) pending_reqs.push_back(mk_req(REQ_REMOVE, 100 + i));
        drain();

        // random phases with several register settings; the first is calm
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_THRESH, ph == 0 ? 16'hffff : ph == 1 ? 16'd1 : $urandom_range(1, 600));
            write_reg(CFG_OFFSET, ph == 0 ? 16'd65472 : $urandom_range(0, 65472));
            calm = (ph == 0);
            for (int k = 0; k < 50; k++) pending_reqs.push_back(rand_req(40));
            drain();
        end
        calm = 1'b0;
        // huge threshold with fast rates: accumulators climb without a step
        write_reg(CFG_THRESH, 16'hffff);
        for (int i = 0; i < 8; i++) begin
            q = mk_req(REQ_ADD, 16'd7000 + i); q.frame_rate = 8'hff; pending_reqs.push_back(q);
        end
        for (int i = 0; i < 24; i++) pending_reqs.push_back(mk_req(REQ_TICK, 0));
        pending_reqs.push_back(mk_req(REQ_VIEW, 0));
        drain();

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
